// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the rtl files that check their own logic
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset has been released
`define CPR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every clock edge, reset included
`define CPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// types, register map and codes of the chunked pdu reassembler
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;

    // header lengths in bytes
    localparam logic [2:0] BASE_HEADER  = 3'd2;
    localparam logic [2:0] FIRST_HEADER = 3'd6;

    // pdu status codes
    localparam logic [1:0] ST_NEED_MORE = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_IGNORED   = 2'd2;
    localparam logic [1:0] ST_ERROR     = 2'd3;

    // pdu still taking payload, no verdict yet
    localparam logic [1:0] VERDICT_NONE = 2'd0;

    // register map
    localparam int          APB_ADDR_W    = 4;
    localparam int          APB_DATA_W    = 32;
    localparam logic [1:0]  REG_CAPACITY  = 2'd0;
    localparam logic [1:0]  REG_LAST_MASK = 2'd1;
    localparam logic [1:0]  REG_TOTAL_MASK = 2'd2;

    localparam logic [15:0] CAPACITY_RESET   = 16'd4096;
    localparam logic [7:0]  LAST_MASK_RESET  = 8'h01;
    localparam logic [7:0]  TOTAL_MASK_RESET = 8'h02;

    typedef struct packed {
        logic [7:0] pdu_byte;
        logic       pdu_end;
    } item_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [15:0] data_offset;
        logic        status_valid;
        logic [1:0]  status;
        logic [15:0] received_length;
    } result_t;

    typedef struct packed {
        logic [15:0] capacity_bytes;
        logic [7:0]  last_flag_mask;
        logic [7:0]  total_flag_mask;
    } cfg_t;

endpackage

// ===== rtl/core/cpr_apb_regs.sv =====
// ----------------------------------------------------------------------------
// cpr_apb_regs
// apb register file holding capacity and flag masks
// ----------------------------------------------------------------------------
module cpr_apb_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cpr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cpr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cpr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output cpr_pkg::cfg_t                      cfg
);

    cpr_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.capacity_bytes  <= cpr_pkg::CAPACITY_RESET;
            cfg_reg.last_flag_mask  <= cpr_pkg::LAST_MASK_RESET;
            cfg_reg.total_flag_mask <= cpr_pkg::TOTAL_MASK_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                cpr_pkg::REG_CAPACITY:   cfg_reg.capacity_bytes  <= pwdata[15:0];
                cpr_pkg::REG_LAST_MASK:  cfg_reg.last_flag_mask  <= pwdata[7:0];
                cpr_pkg::REG_TOTAL_MASK: cfg_reg.total_flag_mask <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cpr_pkg::REG_CAPACITY:   prdata = {16'd0, cfg_reg.capacity_bytes};
            cpr_pkg::REG_LAST_MASK:  prdata = {24'd0, cfg_reg.last_flag_mask};
            cpr_pkg::REG_TOTAL_MASK: prdata = {24'd0, cfg_reg.total_flag_mask};
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/cpr_in_stage.sv =====
// ----------------------------------------------------------------------------
// cpr_in_stage
// input register for one pdu byte
// ----------------------------------------------------------------------------
module cpr_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cpr_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output cpr_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    cpr_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/core/cpr_parser.sv =====
// ----------------------------------------------------------------------------
// cpr_parser
// header parse, sequence and length checks and message state for one byte
// ----------------------------------------------------------------------------
module cpr_parser #(
    parameter int LENGTH_BITS = cpr_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cpr_pkg::cfg_t    cfg,
    input  cpr_pkg::item_t   item,
    input  logic             step,
    output logic             result_present,
    output cpr_pkg::result_t result
);

    // counts never exceed the message total, which is capped at 16 bits
    localparam int          CNT_W     = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
    localparam logic [31:0] LIMIT_MAX = (32'd1 << CNT_W) - 32'd1;

    logic [2:0]       hp_reg, hp_next;
    logic [7:0]       seq_reg, seq_next;
    logic [7:0]       flags_reg, flags_next;
    logic [23:0]      wtot_reg, wtot_next;
    logic [CNT_W-1:0] mtot_reg, mtot_next;
    logic [CNT_W-1:0] rcnt_reg, rcnt_next;
    logic [7:0]       eseq_reg, eseq_next;
    logic             asm_reg, asm_next;
    logic [1:0]       verdict_reg, verdict_next;
    logic [CNT_W-1:0] pcnt_reg, pcnt_next;

    logic             first;
    logic             first_after;
    logic [2:0]       hdr_len;
    logic [2:0]       hdr_len_after;
    logic [31:0]      total32;
    logic             too_big;
    logic [CNT_W-1:0] off;
    logic             have_data;
    logic [1:0]       st;

    assign first   = |(flags_reg & cfg.total_flag_mask);
    assign hdr_len = first ? cpr_pkg::FIRST_HEADER : cpr_pkg::BASE_HEADER;
    assign total32 = {item.pdu_byte, wtot_reg};
    assign too_big = (total32 > {16'd0, cfg.capacity_bytes}) || (total32 > LIMIT_MAX);
    assign off     = rcnt_reg + pcnt_reg;

    always_comb begin
        hp_next       = hp_reg;
        seq_next      = seq_reg;
        flags_next    = flags_reg;
        wtot_next     = wtot_reg;
        mtot_next     = mtot_reg;
        rcnt_next     = rcnt_reg;
        eseq_next     = eseq_reg;
        asm_next      = asm_reg;
        verdict_next  = verdict_reg;
        pcnt_next     = pcnt_reg;
        have_data     = 1'b0;
        st            = cpr_pkg::ST_NEED_MORE;
        first_after   = 1'b0;
        hdr_len_after = cpr_pkg::BASE_HEADER;

        if (hp_reg == 3'd0) begin
            seq_next = item.pdu_byte;
            hp_next  = 3'd1;
        end else if (hp_reg == 3'd1) begin
            flags_next = item.pdu_byte;
            hp_next    = 3'd2;
            // short header: check against the message in progress now
            if (!(|(item.pdu_byte & cfg.total_flag_mask))) begin
                if (!asm_reg) begin
                    verdict_next = cpr_pkg::ST_IGNORED;
                end else if (seq_reg != eseq_reg) begin
                    mtot_next    = '0;
                    rcnt_next    = '0;
                    eseq_next    = '0;
                    asm_next     = 1'b0;
                    verdict_next = cpr_pkg::ST_ERROR;
                end
            end
        end else if (hp_reg < hdr_len) begin
            hp_next = 3'(hp_reg + 3'd1);
            case (hp_reg)
                3'd2:    wtot_next[7:0]   = item.pdu_byte;
                3'd3:    wtot_next[15:8]  = item.pdu_byte;
                3'd4:    wtot_next[23:16] = item.pdu_byte;
                default: ;
            endcase
            // last length byte: a new message starts, unless it is too big or its sequence is not zero
            if (hp_reg == 3'd5) begin
                if (too_big || (seq_reg != 8'd0)) begin
                    mtot_next    = '0;
                    rcnt_next    = '0;
                    eseq_next    = '0;
                    asm_next     = 1'b0;
                    verdict_next = cpr_pkg::ST_ERROR;
                end else begin
                    mtot_next = total32[CNT_W-1:0];
                    rcnt_next = '0;
                    eseq_next = '0;
                    asm_next  = 1'b1;
                end
            end
        end else if (verdict_reg == cpr_pkg::VERDICT_NONE) begin
            if (off >= mtot_reg) begin
                mtot_next    = '0;
                rcnt_next    = '0;
                eseq_next    = '0;
                asm_next     = 1'b0;
                verdict_next = cpr_pkg::ST_ERROR;
            end else begin
                have_data = 1'b1;
                pcnt_next = pcnt_reg + CNT_W'(1);
            end
        end

        if (item.pdu_end) begin
            first_after   = |(flags_next & cfg.total_flag_mask);
            hdr_len_after = first_after ? cpr_pkg::FIRST_HEADER : cpr_pkg::BASE_HEADER;
            if (hp_next < hdr_len_after) begin
                st = cpr_pkg::ST_IGNORED;
            end else if (verdict_next != cpr_pkg::VERDICT_NONE) begin
                st = verdict_next;
            end else begin
                rcnt_next = rcnt_next + pcnt_next;
                eseq_next = eseq_next + 8'd1;
                st = (|(flags_next & cfg.last_flag_mask)) ? cpr_pkg::ST_DONE
                                                          : cpr_pkg::ST_NEED_MORE;
            end
            hp_next      = '0;
            seq_next     = '0;
            flags_next   = '0;
            wtot_next    = '0;
            verdict_next = cpr_pkg::VERDICT_NONE;
            pcnt_next    = '0;
        end
    end

    always_comb begin
        result                 = '0;
        result_present         = have_data || item.pdu_end;
        if (have_data) begin
            result.data_valid  = 1'b1;
            result.data_byte   = item.pdu_byte;
            result.data_offset = 16'(off);
        end
        if (item.pdu_end) begin
            result.status_valid    = 1'b1;
            result.status          = st;
            result.received_length = 16'(rcnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_reg      <= '0;
            seq_reg     <= '0;
            flags_reg   <= '0;
            wtot_reg    <= '0;
            mtot_reg    <= '0;
            rcnt_reg    <= '0;
            eseq_reg    <= '0;
            asm_reg     <= 1'b0;
            verdict_reg <= cpr_pkg::VERDICT_NONE;
            pcnt_reg    <= '0;
        end else if (step) begin
            hp_reg      <= hp_next;
            seq_reg     <= seq_next;
            flags_reg   <= flags_next;
            wtot_reg    <= wtot_next;
            mtot_reg    <= mtot_next;
            rcnt_reg    <= rcnt_next;
            eseq_reg    <= eseq_next;
            asm_reg     <= asm_next;
            verdict_reg <= verdict_next;
            pcnt_reg    <= pcnt_next;
        end
    end

endmodule

// ===== rtl/core/cpr_out_stage.sv =====
// ----------------------------------------------------------------------------
// cpr_out_stage
// result register toward the downstream channel
// ----------------------------------------------------------------------------
module cpr_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  cpr_pkg::result_t result,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output cpr_pkg::result_t m_result
);

    logic             valid_reg;
    logic             valid_next;
    cpr_pkg::result_t result_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// ===== rtl/core/chunked_pdu_reassembler_unit.sv =====
// ----------------------------------------------------------------------------
// chunked_pdu_reassembler_unit
// reassembles messages from chunked radio pdus, one byte per request
//
//   channel   dir   handshake          payload
//   s_        in    s_valid/s_ready    cpr_pkg::item_t   (pdu_byte, pdu_end)
//   m_        out   m_valid/m_ready    cpr_pkg::result_t (data + status)
//   apb       in    psel/penable       capacity, last and total flag masks
//
// one byte per cycle sustained while the m_ side is not stalled; from s_ to m_ a
// byte passes the input register, one pass of parse logic and the result register
// a byte with no payload and no pdu end produces no result request
// synchronous active low reset clears all message and pdu state
// a stalled m_ side holds the result register and backs up into s_ready
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chunked_pdu_reassembler_unit #(
    parameter int LENGTH_BITS = cpr_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // byte input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cpr_pkg::item_t                  s_item,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output cpr_pkg::result_t                m_result,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cpr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cpr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    cpr_pkg::cfg_t    cfg;
    cpr_pkg::item_t   item;
    cpr_pkg::result_t result;
    logic             item_valid;
    logic             out_free;
    logic             advance;
    logic             result_present;

    // a held byte moves on whenever the result register can take its result
    assign advance = item_valid && out_free;

    cpr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    cpr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // header parse and message bookkeeping, state moves once per byte
    cpr_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .item           (item),
        .step           (advance),
        .result_present (result_present),
        .result         (result)
    );

    // result register
    cpr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && result_present),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // every result carries a payload byte, a status, or both
    `CPR_ASSERT(a_result_nonempty, aclk, aresetn, m_valid |-> (m_result.data_valid || m_result.status_valid), "empty result request")

    // an errored pdu reports no received length
    `CPR_ASSERT(a_error_len_zero, aclk, aresetn, (m_valid && m_result.status_valid && (m_result.status == cpr_pkg::ST_ERROR)) |-> (m_result.received_length == 16'd0), "error status with nonzero length")

    // unused result fields stay zero
    `CPR_ASSERT(a_no_data_zero, aclk, aresetn, (m_valid && !m_result.data_valid) |-> ((m_result.data_byte == 8'd0) && (m_result.data_offset == 16'd0)), "stale data fields")

    // nothing is offered in the cycle after reset
    `CPR_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule
